// ----- rtl/core/rnga_pkg.sv -----
package rnga_pkg;

    // Fixed field widths of the stream and configuration channels and of the client state
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 6;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;
    localparam int STATE_W   = 2;

    localparam logic [CNT_W-1:0] CNT_RESET = 7'd5;

    typedef enum logic [0:0] {
        OP_REQUEST = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [STATE_W-1:0] {
        CS_THINKING = 2'd0,
        CS_HUNGRY   = 2'd1,
        CS_EATING   = 2'd2
    } cstate_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_RD_T,
        S_RD_L,
        S_RD_R,
        S_EVAL,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic wr_self;
        logic rd_t;
        logic rd_l;
        logic rd_r;
        logic eval;
        logic next_tgt;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad_in;
        logic op;
        logic phase;
    } dp_stat_t;

endpackage

// ----- rtl/core/ring_neighbor_grant_arbiter.sv -----
// Ring neighbor grant arbiter: clients in a ring, neighbors share a resource.
// Slave stream carries one command per transaction: s_tuser is the operation
// (request or release), s_tdata the client index. The master stream returns one
// result per command: grant flags, both neighbor indexes and the bad-index flag.
// client_count is written over the cfg_valid/cfg_ready channel; the user must write it
// only while idle, and the block does not enforce it. Client states live in a RAM
// with one write and one read port and registered read; every access to it is one
// sequencer step. A request writes its own state, then reads itself and both
// neighbors and evaluates; a release writes its own state, then reads and evaluates
// its left, then its right neighbor; a bad index skips to the result. One at a time.
// The result sits in an output register; a stalled master holds it, and the
// block finishes the next command up to the point of loading it.
// After reset a clearing pass writes every client to thinking with s_tready
// low; configuration writes are taken during it.
// client_count resets to 5.
module ring_neighbor_grant_arbiter
    import rnga_pkg::*;
#(
    parameter int MAX_CLIENTS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_W-1:0]    cfg_data,   // client_count
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // client_index[5:0], zero pad
    input  logic                s_tuser,    // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata     // self_granted, left_granted, right_granted,
                                            // left_index[5:0], right_index[5:0], bad_index
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rnga_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rnga_datapath #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .s_op     (s_tuser),
        .s_index  (s_tdata[IDX_W-1:0]),
        .cmd      (cmd),
        .stat     (stat),
        .m_tdata  (m_tdata)
    );

    // a flagged index carries no grants and no neighbor indexes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[M_DATA_W-1]) |-> (m_tdata[M_DATA_W-2:0] == '0))
        else $error("bad index result carries payload");

    // a request grant excludes neighbor grants
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (!m_tdata[1] && !m_tdata[2]))
        else $error("self grant together with neighbor grant");

    // one command at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while previous one in progress");

    // clearing pass follows reset
    assert property (@(posedge aclk)
        !aresetn |=> (!s_tready && !m_tvalid))
        else $error("ready or valid during clearing pass");

endmodule

// ----- rtl/core/rnga_ram.sv -----
module rnga_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/rnga_datapath.sv -----
module rnga_datapath
    import rnga_pkg::*;
#(
    parameter int MAX_CLIENTS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_data,
    input  logic                s_op,
    input  logic [IDX_W-1:0]    s_index,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW      = $clog2(MAX_CLIENTS);
    localparam int NW      = (AW > CNT_W) ? AW : CNT_W;
    localparam int MAX_CAP = (MAX_CLIENTS > 127) ? 127 : MAX_CLIENTS;

    function automatic logic [CNT_W-1:0] ring_left(input logic [CNT_W-1:0] i,
                                                   input logic [CNT_W-1:0] cnt);
        return (i == '0) ? cnt - 1'b1 : i - 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] ring_right(input logic [CNT_W-1:0] i,
                                                    input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] nxt;
        nxt = i + 1'b1;
        return (nxt >= cnt) ? '0 : nxt;
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] v);
        logic [NW-1:0] w;
        w = NW'(v);
        return w[AW-1:0];
    endfunction

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   eff_count;
    logic [CNT_W-1:0]   idx_in;
    logic [AW-1:0]      clr_cnt_reg;
    logic               op_reg;
    logic               phase_reg;
    logic               bad_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   l_reg;
    logic [CNT_W-1:0]   r_reg;
    logic [CNT_W-1:0]   tgt_reg;
    logic [STATE_W-1:0] st_t_reg;
    logic [STATE_W-1:0] st_l_reg;
    logic               self_g_reg;
    logic               left_g_reg;
    logic               right_g_reg;
    logic [M_DATA_W-1:0] out_reg;

    logic               grant;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [STATE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [STATE_W-1:0] ram_rdata;

    assign eff_count = (count_reg > CNT_W'(MAX_CAP)) ? CNT_W'(MAX_CAP) : count_reg;
    assign idx_in    = CNT_W'(s_index);

    assign stat.clr_last = (clr_cnt_reg == AW'(MAX_CLIENTS - 1));
    assign stat.bad_in   = (idx_in >= eff_count);
    assign stat.op       = op_reg;
    assign stat.phase    = phase_reg;

    assign grant = (st_t_reg == CS_HUNGRY) && (st_l_reg != CS_EATING)
                && (ram_rdata != CS_EATING);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = to_addr(tgt_reg);
        ram_wdata = CS_EATING;
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = CS_THINKING;
        end else if (cmd.wr_self) begin
            ram_we    = 1'b1;
            ram_waddr = to_addr(idx_reg);
            ram_wdata = (op_reg == OP_RELEASE) ? CS_THINKING : CS_HUNGRY;
        end else if (cmd.eval) begin
            ram_we = grant;
        end
    end

    always_comb begin
        ram_raddr = '0;
        if (cmd.rd_t) begin
            ram_raddr = to_addr(tgt_reg);
        end else if (cmd.rd_l) begin
            ram_raddr = to_addr(ring_left(tgt_reg, eff_count));
        end else if (cmd.rd_r) begin
            ram_raddr = to_addr(ring_right(tgt_reg, eff_count));
        end
    end

    rnga_ram #(
        .WIDTH (STATE_W),
        .DEPTH (MAX_CLIENTS)
    ) u_state_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= CNT_RESET;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_data;
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg      <= s_op;
            idx_reg     <= idx_in;
            bad_reg     <= stat.bad_in;
            l_reg       <= ring_left(idx_in, eff_count);
            r_reg       <= ring_right(idx_in, eff_count);
            tgt_reg     <= (s_op == OP_RELEASE) ? ring_left(idx_in, eff_count) : idx_in;
            phase_reg   <= 1'b0;
            self_g_reg  <= 1'b0;
            left_g_reg  <= 1'b0;
            right_g_reg <= 1'b0;
        end
        if (cmd.rd_l) begin
            st_t_reg <= ram_rdata;
        end
        if (cmd.rd_r) begin
            st_l_reg <= ram_rdata;
        end
        if (cmd.eval && grant) begin
            if (op_reg == OP_REQUEST) begin
                self_g_reg <= 1'b1;
            end else if (phase_reg) begin
                right_g_reg <= 1'b1;
            end else begin
                left_g_reg <= 1'b1;
            end
        end
        // advance to the right neighbour test of a release
        if (cmd.next_tgt) begin
            tgt_reg   <= r_reg;
            phase_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            if (bad_reg) begin
                out_reg <= {1'b1, {(M_DATA_W-1){1'b0}}};
            end else begin
                out_reg <= {1'b0, r_reg[IDX_W-1:0], l_reg[IDX_W-1:0],
                            right_g_reg, left_g_reg, self_g_reg};
            end
        end
    end

    assign m_tdata = out_reg;

endmodule

// ----- rtl/core/rnga_ctrl.sv -----
module rnga_ctrl
    import rnga_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    fsm_t state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;
    logic accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (stat.clr_last) state_next = S_IDLE;
            S_IDLE: begin
                if (accept) state_next = stat.bad_in ? S_DONE : S_WRITE;
            end
            S_WRITE: state_next = S_RD_T;
            S_RD_T:  state_next = S_RD_L;
            S_RD_L:  state_next = S_RD_R;
            S_RD_R:  state_next = S_EVAL;
            S_EVAL: begin
                if (stat.op == OP_RELEASE && !stat.phase) begin
                    state_next = S_RD_T;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_CLEAR: cmd.clr_step = 1'b1;
            S_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = accept;
            end
            S_WRITE: cmd.wr_self = 1'b1;
            S_RD_T:  cmd.rd_t    = 1'b1;
            S_RD_L:  cmd.rd_l    = 1'b1;
            S_RD_R:  cmd.rd_r    = 1'b1;
            S_EVAL: begin
                cmd.eval     = 1'b1;
                cmd.next_tgt = (stat.op == OP_RELEASE) && !stat.phase;
            end
            S_DONE:  cmd.out_load = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- tb/ring_neighbor_grant_arbiter_test.sv -----
`timescale 1ns / 100ps

module ring_neighbor_grant_arbiter_test;
    import rnga_pkg::*;

    localparam int RING_SLOTS   = 64;
    localparam int DRAIN_CYCLES = 16;   // longer than a release takes through the sequencer, with margin
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_CAP    = 100;

    // m_tdata layout from bit 0 up: self, left, right grant, left index,
    // right index, bad index
    typedef struct packed {
        logic             bad_index;
        logic [IDX_W-1:0] right_index;
        logic [IDX_W-1:0] left_index;
        logic             right_granted;
        logic             left_granted;
        logic             self_granted;
    } grant_result_t;

    class grant_scoreboard;
        cstate_t          clients [RING_SLOTS];
        logic [CNT_W-1:0] client_count;
        grant_result_t    pending_results [$];
        int unsigned      errors;
        int unsigned      commands;
        int unsigned      results;
        int unsigned      grants;
        int unsigned      bad_hits;
        int unsigned      config_writes;

        function new();
            foreach (clients[k]) clients[k] = CS_THINKING;
            client_count  = CNT_RESET;
            errors        = 0;
            commands      = 0;
            results       = 0;
            grants        = 0;
            bad_hits      = 0;
            config_writes = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] value);
            client_count = value;
            config_writes++;
        endfunction

        // Saturate the configured count at the number of state slots
        function int unsigned ring_size();
            return (client_count > RING_SLOTS) ? RING_SLOTS : client_count;
        endfunction

        function int unsigned left_of(int unsigned i, int unsigned n);
            return (i == 0) ? n - 1 : i - 1;
        endfunction

        function int unsigned right_of(int unsigned i, int unsigned n);
            return (i + 1 >= n) ? 0 : i + 1;
        endfunction

        function logic grant_if_free(int unsigned i, int unsigned n);
            if (clients[i] == CS_HUNGRY && clients[left_of(i, n)] != CS_EATING &&
                clients[right_of(i, n)] != CS_EATING) begin
                clients[i] = CS_EATING;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_command(op_t op, logic [IDX_W-1:0] idx);
            int unsigned   n;
            int unsigned   l;
            int unsigned   r;
            grant_result_t want;
            n    = ring_size();
            want = '0;
            commands++;
            if (idx >= n) begin
                want.bad_index = 1'b1;
            end else begin
                l = left_of(idx, n);
                r = right_of(idx, n);
                want.left_index  = IDX_W'(l);
                want.right_index = IDX_W'(r);
                if (op == OP_REQUEST) begin
                    clients[idx] = CS_HUNGRY;
                    want.self_granted = grant_if_free(idx, n);
                end else begin
                    // left neighbor is tested first; in a ring of two it wins
                    clients[idx] = CS_THINKING;
                    want.left_granted  = grant_if_free(l, n);
                    want.right_granted = grant_if_free(r, n);
                end
            end
            pending_results.push_back(want);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            if (errors < PRINT_CAP)
                $display("MISMATCH at %0t, result %0d, %s: got 0x%0h, want 0x%0h",
                         $time, results, what, got, want);
            errors++;
        endtask

        task check_result(logic [M_DATA_W-1:0] word);
            grant_result_t got;
            grant_result_t want;
            got = grant_result_t'(word);
            if (pending_results.size() == 0) begin
                report_mismatch("result with no command pending", word, 0);
                return;
            end
            want = pending_results.pop_front();
            results++;
            if (got.self_granted !== want.self_granted)
                report_mismatch("self_granted", got.self_granted, want.self_granted);
            if (got.left_granted !== want.left_granted)
                report_mismatch("left_granted", got.left_granted, want.left_granted);
            if (got.right_granted !== want.right_granted)
                report_mismatch("right_granted", got.right_granted, want.right_granted);
            if (got.left_index !== want.left_index)
                report_mismatch("left_index", got.left_index, want.left_index);
            if (got.right_index !== want.right_index)
                report_mismatch("right_index", got.right_index, want.right_index);
            if (got.bad_index !== want.bad_index)
                report_mismatch("bad_index", got.bad_index, want.bad_index);
            grants   += want.self_granted + want.left_granted + want.right_granted;
            bad_hits += want.bad_index;
        endtask
    endclass

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CNT_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    grant_scoreboard sb = new();
    bit              src_steady;
    bit              sink_steady;
    int unsigned     hold_off_request;

    ring_neighbor_grant_arbiter #(
        .MAX_CLIENTS(RING_SLOTS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic send_command(op_t op, logic [IDX_W-1:0] idx);
        int unsigned gap;
        gap = pick_gap(src_steady);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_DATA_W'(idx);
        do @(posedge aclk); while (!s_tready);
        sb.note_command(op, idx);
    endtask

    // Drop valid, wait for every result, then let the sequencer settle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_count(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(logic [CNT_W-1:0] count, int unsigned items, bit hold);
        int unsigned      n;
        int unsigned      center;
        int unsigned      r;
        logic [IDX_W-1:0] idx;
        write_count(count);
        // stall the result side while commands keep coming
        if (hold) hold_off_request = HOLD_CYCLES;
        n      = sb.ring_size();
        center = (n != 0) ? $urandom_range(0, n - 1) : 0;
        repeat (items) begin
            r = $urandom_range(0, 99);
            if (n == 0 || r < 15) begin
                idx = $urandom_range(0, RING_SLOTS - 1);
            end else if (r < 75) begin
                // cluster on a few neighbors so hungry clients get blocked and granted
                if ($urandom_range(0, 9) == 0) center = $urandom_range(0, n - 1);
                idx = (center + $urandom_range(0, 3)) % n;
            end else begin
                idx = $urandom_range(0, n - 1);
            end
            send_command(op_t'($urandom_range(0, 1)), idx);
        end
    endtask

    // Result side: random backpressure, long hold on request
    initial begin : sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_request != 0) begin
                stall_left       = hold_off_request;
                hold_off_request = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (sink_steady || $urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                stall_left = pick_gap(1'b0);
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    initial begin : stimulus
        int unsigned phase_counts [12];
        phase_counts = '{1, 2, 3, 0, 64, 127, 7, 65, 3, 64, 0, 0};
        phase_counts[10] = $urandom_range(1, 127);
        phase_counts[11] = $urandom_range(0, 127);
        src_steady       = 1'b0;
        sink_steady      = 1'b0;
        hold_off_request = 0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // ring of five from reset: block, grant, grant on release, re-request while eating
        send_command(OP_REQUEST, 0);
        send_command(OP_REQUEST, 1);
        send_command(OP_REQUEST, 4);
        send_command(OP_REQUEST, 2);
        send_command(OP_RELEASE, 0);
        send_command(OP_RELEASE, 2);
        send_command(OP_REQUEST, 4);
        send_command(OP_RELEASE, 3);
        send_command(OP_REQUEST, 5);
        send_command(OP_RELEASE, 63);
        // ring of one: the client is its own neighbor
        write_count(1);
        send_command(OP_REQUEST, 0);
        send_command(OP_REQUEST, 0);
        send_command(OP_RELEASE, 0);
        send_command(OP_REQUEST, 1);
        // ring of two: both neighbors are the same client
        write_count(2);
        send_command(OP_REQUEST, 0);
        send_command(OP_REQUEST, 1);
        send_command(OP_RELEASE, 0);
        send_command(OP_RELEASE, 1);
        // empty ring: everything is out of range
        write_count(0);
        send_command(OP_REQUEST, 0);
        // count above capacity: wrap at the top slot
        write_count(127);
        send_command(OP_REQUEST, 63);
        send_command(OP_REQUEST, 0);
        send_command(OP_RELEASE, 63);

        foreach (phase_counts[p]) begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            if (p == 4) begin
                src_steady = 1'b1;
            end
            random_phase(CNT_W'(phase_counts[p]), (phase_counts[p] == 0) ? 20 : 64,
                         p == 4);
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        wait_idle();

        $display("covered %0d commands and %0d results over %0d ring-size writes",
                 sb.commands, sb.results, sb.config_writes);
        $display("saw %0d grants and %0d out-of-range commands", sb.grants, sb.bad_hits);
        if (sb.errors == 0) begin
            $display("ring_neighbor_grant_arbiter_test OK");
        end else begin
            $display("ring_neighbor_grant_arbiter_test NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("timeout with %0d results still pending", sb.pending_results.size());
        $display("ring_neighbor_grant_arbiter_test NOT OK");
        $finish;
    end

endmodule
